### rtl/gsar_pkg.sv
`timescale 1ns / 1ps
package gsar_pkg;

  // Channel count and fixed field widths
  localparam int NCH        = 3;
  localparam int SAMPLE_W   = 12;
  localparam int AVG_W      = 12;
  localparam int RES_W      = 32;
  localparam int LOAD_W     = 20;
  localparam int FS_W       = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  // Divider operand widths
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FS   = 1'd1;

  localparam logic [RES_W-1:0] RES_SAT = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_co;
    logic [SAMPLE_W-1:0] sample_no2;
    logic [SAMPLE_W-1:0] sample_nh3;
  } in_item_t;

  typedef struct packed {
    logic [AVG_W-1:0] average_co;
    logic [AVG_W-1:0] average_no2;
    logic [AVG_W-1:0] average_nh3;
    logic [RES_W-1:0] resistance_co;
    logic [RES_W-1:0] resistance_no2;
    logic [RES_W-1:0] resistance_nh3;
    logic [NCH-1:0]   saturated_mask;
  } out_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_AVG,
    B_MUL,
    B_CHECK,
    B_RES_WAIT,
    B_OUT
  } back_state_t;

endpackage

### rtl/gas_sensor_avg_resistance.sv
`timescale 1ns / 1ps
// Path: an accepted item passes the front and the middle queue, then each channel in turn
//   goes through the back sequencer, and the result is loaded into the result queue.
// The back sequencer works on one item at a time and shares one radix-4 divider among the
//   channels; a saturated channel skips its division.
// Reset: synchronous, active low; sums, write index and ring valid bits clear at once,
//   configuration returns to 10000 ohms load and 4096 full scale.
module gas_sensor_avg_resistance
  import gsar_pkg::*;
#(
  parameter int WINDOW   = 16,
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KEEP  = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int SUM_W = KEEP + $clog2(WINDOW);
  localparam int MID_W = NCH * SUM_W;
  localparam int OUT_W = $bits(out_item_t);

  logic [LOAD_W-1:0]         load_r;
  logic [FS_W-1:0]           fs_r;
  logic                      accept;
  logic                      front_busy;
  logic                      mid_push, mid_pop, mid_full, mid_empty;
  logic [NCH-1:0][SUM_W-1:0] front_sums;
  logic [MID_W-1:0]          mid_rdata;
  logic                      res_push, res_full;
  out_item_t                 res_data;
  logic [OUT_W-1:0]          out_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= LOAD_W'(10000);
      fs_r   <= FS_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOAD: load_r <= cfg_data[LOAD_W-1:0];
        REG_FS:   fs_r   <= cfg_data[FS_W-1:0];
        default:  ;
      endcase
    end
  end

  assign in_full = front_busy || mid_full;
  assign accept  = in_push && !in_full;

  // Front: ring and running sums
  gsar_front #(
    .WINDOW (WINDOW),
    .KEEP   (KEEP),
    .SUM_W  (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .mid_full (mid_full),
    .busy     (front_busy),
    .mid_push (mid_push),
    .mid_sums (front_sums)
  );

  // Decouple front and back
  gsar_queue #(
    .WIDTH (MID_W),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (front_sums),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  // Back: averages and resistances
  gsar_back #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_res   (load_r),
    .full_scale (fs_r),
    .mid_empty  (mid_empty),
    .mid_sums   (mid_rdata),
    .mid_pop    (mid_pop),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_data   (res_data)
  );

  // Result queue towards the consumer
  gsar_queue #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_item = out_item_t'(out_rdata);

endmodule

### rtl/gsar_queue.sv
`timescale 1ns / 1ps
module gsar_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond depth");
`endif

endmodule

### rtl/gsar_front.sv
`timescale 1ns / 1ps
module gsar_front
  import gsar_pkg::*;
#(
  parameter int WINDOW = 16,
  parameter int KEEP   = 12,
  parameter int SUM_W  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  in_item_t                  item,
  input  logic                      mid_full,
  output logic                      busy,
  output logic                      mid_push,
  output logic [NCH-1:0][SUM_W-1:0] mid_sums
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [NCH-1:0][KEEP-1:0]  ring_r [WINDOW];
  logic [WINDOW-1:0]         valid_r;
  logic [IDX_W-1:0]          wi_r;
  logic                      upd_r;
  logic [NCH-1:0][KEEP-1:0]  rd_r;
  logic                      old_valid_r;
  logic [NCH-1:0][KEEP-1:0]  samp_r;
  logic [NCH-1:0][SUM_W-1:0] sums_r;
  logic [NCH-1:0][SUM_W-1:0] sums_nxt;
  logic [NCH-1:0][KEEP-1:0]  old_samp;
  logic [NCH-1:0][KEEP-1:0]  new_samp;

  // Keep only the low ADC bits of each sample
  assign new_samp[0] = item.sample_co[KEEP-1:0];
  assign new_samp[1] = item.sample_no2[KEEP-1:0];
  assign new_samp[2] = item.sample_nh3[KEEP-1:0];

  // Replace the oldest sample in each running sum
  always_comb begin
    old_samp = old_valid_r ? rd_r : '0;
    for (int c = 0; c < NCH; c++) begin
      sums_nxt[c] = sums_r[c] + SUM_W'(samp_r[c]) - SUM_W'(old_samp[c]);
    end
  end

  assign busy     = upd_r;
  assign mid_push = upd_r;
  assign mid_sums = sums_nxt;

  // Read the oldest slot on accept, overwrite it on the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r        <= ring_r[wi_r];
      old_valid_r <= valid_r[wi_r];
      samp_r      <= new_samp;
    end
    if (upd_r) begin
      ring_r[wi_r] <= samp_r;
    end
  end

  // Hold sums, slot index and slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r   <= 1'b0;
      valid_r <= '0;
      wi_r    <= '0;
      sums_r  <= '0;
    end else begin
      upd_r <= accept;
      if (upd_r) begin
        valid_r[wi_r] <= 1'b1;
        wi_r          <= (wi_r == IDX_W'(WINDOW - 1)) ? '0 : wi_r + 1'b1;
        sums_r        <= sums_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
    upd_r |-> !mid_full)
    else $error("front update with no room in the middle queue");
`endif

endmodule

### rtl/gsar_divider.sv
`timescale 1ns / 1ps
module gsar_divider
  import gsar_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  localparam int STEPS = DIV_N_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [DIV_D_W:0]   rem_r;
  logic [DIV_N_W-1:0] q_r;
  logic [DIV_D_W-1:0] d_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   r1, r2;
  logic               b1, b2;

  // Two restoring steps per cycle
  always_comb begin
    r1 = {rem_r[DIV_D_W-1:0], q_r[DIV_N_W-1]};
    b1 = (r1 >= {1'b0, d_r});
    if (b1) begin
      r1 = r1 - {1'b0, d_r};
    end
    r2 = {r1[DIV_D_W-1:0], q_r[DIV_N_W-2]};
    b2 = (r2 >= {1'b0, d_r});
    if (b2) begin
      r2 = r2 - {1'b0, d_r};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  // Shift dividend out and quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= r2;
      q_r   <= {q_r[DIV_N_W-3:0], b1, b2};
    end
  end

  // Count iterations and flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without a run");
`endif

endmodule

### rtl/gsar_back.sv
`timescale 1ns / 1ps
module gsar_back
  import gsar_pkg::*;
#(
  parameter int WINDOW = 16,
  parameter int SUM_W  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [LOAD_W-1:0]         load_res,
  input  logic [FS_W-1:0]           full_scale,
  input  logic                      mid_empty,
  input  logic [NCH-1:0][SUM_W-1:0] mid_sums,
  output logic                      mid_pop,
  input  logic                      out_full,
  output logic                      out_push,
  output out_item_t                 out_data
);

  localparam bit POW2 = ((WINDOW & (WINDOW - 1)) == 0);
  localparam int SH   = $clog2(WINDOW);

  // Reciprocal of WINDOW, exact for every sum below 2**SUM_W
  localparam int              RCP_S    = SUM_W + SH;
  localparam int              RCP_W    = SUM_W + 2;
  localparam longint unsigned RCP_FULL =
    ((64'd1 << RCP_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RCP_W-1:0] RCP_M   = RCP_W'(RCP_FULL);

  back_state_t                state_r, state_nxt;
  logic [1:0]                 ch_r;
  logic [AVG_W-1:0]           avg_r;
  logic [NCH-1:0][AVG_W-1:0]  avgs_r;
  logic [NCH-1:0][RES_W-1:0]  res_r;
  logic [NCH-1:0]             mask_r;
  logic [DIV_N_W-1:0]         prod_r;
  logic [DIV_D_W-1:0]         den_r;
  logic                       sat_r;
  logic                       last_ch;
  logic                       div_start;
  logic                       div_done;
  logic [DIV_N_W-1:0]         div_num;
  logic [DIV_D_W-1:0]         div_den;
  logic [DIV_N_W-1:0]         div_q;
  logic [SUM_W+RCP_W-1:0]     avg_prod;

  assign last_ch = (ch_r == 2'(NCH - 1));

  // Scale the sum by the reciprocal of the window length
  assign avg_prod = (SUM_W+RCP_W)'(mid_sums[ch_r]) * (SUM_W+RCP_W)'(RCP_M);

  // Divider for the resistance
  gsar_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:     if (!mid_empty) state_nxt = B_AVG;
      B_AVG:      state_nxt = B_MUL;
      B_MUL:      state_nxt = B_CHECK;
      B_CHECK: begin
        if (sat_r) begin
          state_nxt = last_ch ? B_OUT : B_AVG;
        end else begin
          state_nxt = B_RES_WAIT;
        end
      end
      B_RES_WAIT: if (div_done) state_nxt = last_ch ? B_OUT : B_AVG;
      B_OUT:      if (!out_full) state_nxt = B_IDLE;
      default:    state_nxt = B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    div_start = 1'b0;
    div_num   = prod_r;
    div_den   = den_r;
    mid_pop   = 1'b0;
    out_push  = 1'b0;
    unique case (state_r)
      B_CHECK: div_start = !sat_r;
      B_OUT: begin
        mid_pop  = !out_full;
        out_push = !out_full;
      end
      default: ;
    endcase
  end

  // Assemble the result transaction
  always_comb begin
    out_data.average_co     = avgs_r[0];
    out_data.average_no2    = avgs_r[1];
    out_data.average_nh3    = avgs_r[2];
    out_data.resistance_co  = res_r[0];
    out_data.resistance_no2 = res_r[1];
    out_data.resistance_nh3 = res_r[2];
    out_data.saturated_mask = mask_r;
  end

  // Channel datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_AVG: begin
        if (POW2) begin
          avg_r <= AVG_W'(mid_sums[ch_r] >> SH);
        end else begin
          avg_r <= AVG_W'(avg_prod >> RCP_S);
        end
      end
      B_MUL: begin
        prod_r       <= DIV_N_W'(avg_r) * DIV_N_W'(load_res);
        sat_r        <= (FS_W'(avg_r) >= full_scale);
        den_r        <= DIV_D_W'(full_scale - FS_W'(avg_r));
        avgs_r[ch_r] <= avg_r;
      end
      B_CHECK: begin
        mask_r[ch_r] <= sat_r;
        if (sat_r) begin
          res_r[ch_r] <= RES_SAT;
        end
      end
      B_RES_WAIT: begin
        if (div_done) begin
          res_r[ch_r] <= div_q;
        end
      end
      default: ;
    endcase
  end

  // Hold state and channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE) begin
        ch_r <= '0;
      end else if ((state_r == B_CHECK && sat_r) || (state_r == B_RES_WAIT && div_done)) begin
        ch_r <= last_ch ? '0 : ch_r + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (!out_full && !mid_empty))
    else $error("result pushed without room or source");
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= 2'(NCH - 1))
    else $error("channel counter out of range");
`endif

endmodule
